>>> rtl/mrre_pkg.sv
// Package for the mask run rectangle extractor: payload types, codes and states.
package mrre_pkg;

    localparam int WORD_BITS = 16;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int COORD_W   = 13;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_WORD  = 1'b1;

    localparam logic [1:0] CFG_PHASE_X     = 2'd0;
    localparam logic [1:0] CFG_PHASE_Y     = 2'd1;
    localparam logic [1:0] CFG_MASK_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_MASK_HEIGHT = 2'd3;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic        [14:0] rect_w;
        logic        [14:0] rect_h;
        logic        [15:0] mask_bits;
    } t_in_req;

    typedef struct packed {
        logic               has_rect;
        logic signed [15:0] out_x0;
        logic signed [15:0] out_y0;
        logic signed [15:0] out_x1;
        logic signed [15:0] out_y1;
        logic               last;
    } t_out_res;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } t_rect;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_END,
        S_FLUSH
    } t_state;

endpackage

>>> rtl/mask_run_rectangle_extractor_core.sv
// Top level of the mask run rectangle extractor: window clip, run scan, rectangle merge.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in  (t_in_req)
//  out     | output    | o_out_valid / i_out_ready  | o_out (t_out_res)
//  cfg     | input     | i_cfg_we                   | i_cfg_addr, i_cfg_data
//
// A start request is taken in the idle state. A mask word is taken in the idle state, then
// its WORD_BITS columns pass the column scanner, one column per cycle unless stalled, then
// the end state follows at the end of a window row and the flush state at the window's end.
// Any cycle that must send a rectangle waits while the output register is full, and the
// input is not ready while the output register holds a result that is not taken.
// Synchronous active-low reset; no clearing pass.
module mask_run_rectangle_extractor_core #(
    parameter int MAX_MASK_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mrre_pkg::t_in_req  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mrre_pkg::t_out_res o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data
);
    import mrre_pkg::*;

    localparam logic [15:0] MaxDim = 16'(MAX_MASK_DIM);

    t_state               r_state, n_state;
    logic signed [15:0]   r_phase_x, r_phase_y;
    logic [COORD_W-1:0]   r_mask_w, r_mask_h;
    logic [COORD_W-1:0]   r_win_left, r_win_right, r_win_bottom;
    logic [COORD_W-1:0]   n_win_left, n_win_right, n_win_bottom;
    logic [COORD_W-1:0]   r_cur_row, n_cur_row;
    logic [COORD_W-1:0]   r_word_col, n_word_col;
    logic                 r_run_open, n_run_open;
    logic [COORD_W-1:0]   r_run_start, n_run_start;
    logic                 r_held_valid, n_held_valid;
    t_rect                r_held, n_held;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [WORD_BITS-1:0] r_bits, n_bits;
    logic                 r_out_valid, n_out_valid;
    t_out_res             r_out, n_out;

    logic                 in_acc, can_emit, active;
    logic [COORD_W-1:0]   dim_w, dim_h;
    logic signed [17:0]   mx0, my0, mx1, my1, cx0, cy0, cx1, cy1;
    logic                 win_empty;
    logic [COORD_W:0]     col, word_end;
    logic                 col_in, col_one, last_bit, row_done;
    logic                 close_req, close_match, close_emit, stall;
    logic [COORD_W-1:0]   close_x1;
    t_out_res             held_res, empty_res;

    assign can_emit   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && can_emit;
    assign in_acc     = i_in_valid && o_in_ready;
    assign active     = r_cur_row < r_win_bottom;

    assign dim_w = ({3'b0, r_mask_w} > MaxDim) ? MaxDim[COORD_W-1:0] : r_mask_w;
    assign dim_h = ({3'b0, r_mask_h} > MaxDim) ? MaxDim[COORD_W-1:0] : r_mask_h;

    assign mx0 = 18'(i_in.rect_x) + 18'(r_phase_x);
    assign my0 = 18'(i_in.rect_y) + 18'(r_phase_y);
    assign mx1 = mx0 + $signed({3'b0, i_in.rect_w});
    assign my1 = my0 + $signed({3'b0, i_in.rect_h});
    assign cx0 = (mx0 < 0) ? 18'sd0 : mx0;
    assign cy0 = (my0 < 0) ? 18'sd0 : my0;
    assign cx1 = (mx1 > $signed({5'b0, dim_w})) ? $signed({5'b0, dim_w}) : mx1;
    assign cy1 = (my1 > $signed({5'b0, dim_h})) ? $signed({5'b0, dim_h}) : my1;
    assign win_empty = (cx0 >= cx1) || (cy0 >= cy1);

    // column scanner, one column per cycle unless stalled by a full output register
    assign col      = {1'b0, r_word_col} + {{(COORD_W+1-BIT_IDX_W){1'b0}}, r_bit};
    assign col_in   = (col >= {1'b0, r_win_left}) && (col < {1'b0, r_win_right});
    assign col_one  = r_bits[BIT_IDX_W'(WORD_BITS-1) - r_bit];
    assign last_bit = r_bit == BIT_IDX_W'(WORD_BITS-1);
    assign word_end = {1'b0, r_word_col} + (COORD_W+1)'(WORD_BITS);
    assign row_done = word_end >= {1'b0, r_win_right};

    // shared run close and merge unit
    always_comb begin
        close_req = 1'b0;
        close_x1  = r_win_right;
        if (r_state == S_SCAN) begin
            close_req = col_in && !col_one && r_run_open;
            close_x1  = col[COORD_W-1:0];
        end else if (r_state == S_END) begin
            close_req = r_run_open;
        end
    end
    assign close_match = r_held_valid && (r_held.x0 == r_run_start) &&
                         (r_held.x1 == close_x1) && (r_held.y1 == r_cur_row);
    assign close_emit  = close_req && r_held_valid && !close_match;
    assign stall = ((close_emit || r_state == S_FLUSH) && !can_emit);

    always_comb begin
        held_res          = '0;
        held_res.has_rect = 1'b1;
        held_res.out_x0   = $signed({3'b0, r_held.x0}) - r_phase_x;
        held_res.out_y0   = $signed({3'b0, r_held.y0}) - r_phase_y;
        held_res.out_x1   = $signed({3'b0, r_held.x1}) - r_phase_x;
        held_res.out_y1   = $signed({3'b0, r_held.y1}) - r_phase_y;
        empty_res         = '0;
        empty_res.last    = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.cmd == CMD_WORD && active) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stall && last_bit) begin
                    n_state = row_done ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (!stall) begin
                    n_state = (r_cur_row + 1'b1 >= r_win_bottom) ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (!stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_win_left   = r_win_left;
        n_win_right  = r_win_right;
        n_win_bottom = r_win_bottom;
        n_cur_row    = r_cur_row;
        n_word_col   = r_word_col;
        n_run_open   = r_run_open;
        n_run_start  = r_run_start;
        n_held_valid = r_held_valid;
        n_held       = r_held;
        n_bit        = r_bit;
        n_bits       = r_bits;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (close_req && !stall) begin
            n_run_open = 1'b0;
            if (close_match) begin
                n_held.y1 = r_cur_row + 1'b1;
            end else begin
                if (r_held_valid) begin
                    n_out_valid = 1'b1;
                    n_out       = held_res;
                end
                n_held_valid = 1'b1;
                n_held       = '{x0: r_run_start, y0: r_cur_row,
                                 x1: close_x1, y1: r_cur_row + 1'b1};
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.cmd == CMD_START) begin
                    n_run_open   = 1'b0;
                    n_run_start  = '0;
                    n_held_valid = 1'b0;
                    n_held       = '0;
                    if (win_empty) begin
                        n_win_left   = '0;
                        n_win_right  = '0;
                        n_win_bottom = '0;
                        n_cur_row    = '0;
                        n_word_col   = '0;
                        n_out_valid  = 1'b1;
                        n_out        = empty_res;
                    end else begin
                        n_win_left   = cx0[COORD_W-1:0];
                        n_win_right  = cx1[COORD_W-1:0];
                        n_win_bottom = cy1[COORD_W-1:0];
                        n_cur_row    = cy0[COORD_W-1:0];
                        n_word_col   = cx0[COORD_W-1:0] & ~COORD_W'(WORD_BITS-1);
                    end
                end else if (in_acc && active) begin
                    n_bits = i_in.mask_bits[WORD_BITS-1:0];
                    n_bit  = '0;
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    if (col_in && col_one && !r_run_open) begin
                        n_run_open  = 1'b1;
                        n_run_start = col[COORD_W-1:0];
                    end
                    n_bit = r_bit + 1'b1;
                    if (last_bit && !row_done) begin
                        n_word_col = word_end[COORD_W-1:0];
                    end
                end
            end
            S_END: begin
                if (!stall) begin
                    n_cur_row  = r_cur_row + 1'b1;
                    n_word_col = r_win_left & ~COORD_W'(WORD_BITS-1);
                end
            end
            S_FLUSH: begin
                if (!stall) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_held_valid ? held_res : empty_res;
                    n_out.last   = 1'b1;
                    n_held_valid = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase_x    <= '0;
            r_phase_y    <= '0;
            r_mask_w     <= '0;
            r_mask_h     <= '0;
            r_win_left   <= '0;
            r_win_right  <= '0;
            r_win_bottom <= '0;
            r_cur_row    <= '0;
            r_word_col   <= '0;
            r_run_open   <= 1'b0;
            r_run_start  <= '0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
            r_bit        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_win_left   <= n_win_left;
            r_win_right  <= n_win_right;
            r_win_bottom <= n_win_bottom;
            r_cur_row    <= n_cur_row;
            r_word_col   <= n_word_col;
            r_run_open   <= n_run_open;
            r_run_start  <= n_run_start;
            r_held_valid <= n_held_valid;
            r_held       <= n_held;
            r_bit        <= n_bit;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PHASE_X:     r_phase_x <= i_cfg_data;
                    CFG_PHASE_Y:     r_phase_y <= i_cfg_data;
                    CFG_MASK_WIDTH:  r_mask_w  <= i_cfg_data[COORD_W-1:0];
                    CFG_MASK_HEIGHT: r_mask_h  <= i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_held_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_held.y0 < r_held.y1) && (r_held.x0 < r_held.x1))
        else $error("held rectangle is empty");

    a_scan_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_END) |-> active && (r_win_left < r_win_right))
        else $error("scanning without an active window");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.has_rect) |-> o_out.last)
        else $error("result without rectangle not marked last");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && can_emit) |=> !r_held_valid && o_out_valid && o_out.last)
        else $error("final flush did not complete");
`endif

endmodule

>>> tb/mrre_rect_checker.sv
// Checker for the mask run rectangle extractor: mirrors registers, predicts and compares results.
module mrre_rect_checker #(
    parameter int MAX_MASK_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mrre_pkg::t_in_req  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mrre_pkg::t_out_res i_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import mrre_pkg::*;

    logic signed [15:0] phase_x_q;
    logic signed [15:0] phase_y_q;
    logic [12:0]        mask_w_q;
    logic [12:0]        mask_h_q;

    int win_l, win_r, win_t, win_b;
    int row, word_col, run_beg;
    bit run_on, held_on;
    int hx0, hy0, hx1, hy1;
    int fail_q = 0;

    t_out_res expected_rects[$];
    t_out_res want_res;

    assign o_fail_count = fail_q;

    function automatic t_out_res make_res(input bit has, input int x0, input int y0,
                                          input int x1, input int y1, input bit lst);
        t_out_res r;
        r.has_rect = has;
        r.out_x0   = 16'(x0);
        r.out_y0   = 16'(y0);
        r.out_x1   = 16'(x1);
        r.out_y1   = 16'(y1);
        r.last     = lst;
        return r;
    endfunction

    task automatic emit_held(input bit lst);
        int px, py;
        px = int'(phase_x_q);
        py = int'(phase_y_q);
        expected_rects.push_back(make_res(1'b1, hx0 - px, hy0 - py, hx1 - px, hy1 - py, lst));
    endtask

    task automatic close_run(input int x0, input int x1);
        run_on = 1'b0;
        if (held_on && hx0 == x0 && hx1 == x1 && hy1 == row) begin
            hy1 = row + 1;
        end else begin
            if (held_on) emit_held(1'b0);
            held_on = 1'b1;
            hx0 = x0;
            hy0 = row;
            hx1 = x1;
            hy1 = row + 1;
        end
    endtask

    task automatic predict_rects(input t_in_req r);
        int mx0, my0, mx1, my1, w, h, col, b;
        bit one;
        if (r.cmd == CMD_START) begin
            mx0 = int'($signed(r.rect_x)) + int'(phase_x_q);
            my0 = int'($signed(r.rect_y)) + int'(phase_y_q);
            mx1 = mx0 + int'(r.rect_w);
            my1 = my0 + int'(r.rect_h);
            w = (mask_w_q > MAX_MASK_DIM) ? MAX_MASK_DIM : int'(mask_w_q);
            h = (mask_h_q > MAX_MASK_DIM) ? MAX_MASK_DIM : int'(mask_h_q);
            if (mx0 < 0) mx0 = 0;
            if (my0 < 0) my0 = 0;
            if (mx1 > w) mx1 = w;
            if (my1 > h) my1 = h;
            run_on  = 1'b0;
            run_beg = 0;
            held_on = 1'b0;
            hx0 = 0; hy0 = 0; hx1 = 0; hy1 = 0;
            if (mx0 >= mx1 || my0 >= my1) begin
                win_l = 0; win_r = 0; win_t = 0; win_b = 0;
                row = 0;
                word_col = 0;
                expected_rects.push_back(make_res(1'b0, 0, 0, 0, 0, 1'b1));
            end else begin
                win_l = mx0; win_r = mx1; win_t = my0; win_b = my1;
                row = my0;
                word_col = (mx0 / WORD_BITS) * WORD_BITS;
            end
        end else if (row < win_b) begin
            for (b = 0; b < WORD_BITS; b++) begin
                col = word_col + b;
                if (col >= win_l && col < win_r) begin
                    one = r.mask_bits[WORD_BITS-1-b];
                    if (one && !run_on) begin
                        run_on  = 1'b1;
                        run_beg = col;
                    end else if (!one && run_on) begin
                        close_run(run_beg, col);
                    end
                end
            end
            if (word_col + WORD_BITS >= win_r) begin
                if (run_on) close_run(run_beg, win_r);
                row++;
                word_col = (win_l / WORD_BITS) * WORD_BITS;
                if (row >= win_b) begin
                    if (held_on) emit_held(1'b1);
                    else expected_rects.push_back(make_res(1'b0, 0, 0, 0, 0, 1'b1));
                    held_on = 1'b0;
                end
            end else begin
                word_col += WORD_BITS;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            fail_q++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_x_q = '0;
            phase_y_q = '0;
            mask_w_q  = '0;
            mask_h_q  = '0;
            win_l = 0; win_r = 0; win_t = 0; win_b = 0;
            row = 0; word_col = 0; run_beg = 0;
            run_on = 1'b0;
            held_on = 1'b0;
            hx0 = 0; hy0 = 0; hx1 = 0; hy1 = 0;
            expected_rects.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rects.size() == 0) begin
                    fail_q++;
                    $display("%0t: result with nothing expected, expected none, actual %p",
                             $time, i_out);
                end else begin
                    want_res = expected_rects.pop_front();
                    check_field("has_rect", want_res.has_rect, i_out.has_rect);
                    check_field("out_x0", want_res.out_x0, i_out.out_x0);
                    check_field("out_y0", want_res.out_y0, i_out.out_y0);
                    check_field("out_x1", want_res.out_x1, i_out.out_x1);
                    check_field("out_y1", want_res.out_y1, i_out.out_y1);
                    check_field("last", want_res.last, i_out.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PHASE_X:     phase_x_q = i_cfg_data;
                    CFG_PHASE_Y:     phase_y_q = i_cfg_data;
                    CFG_MASK_WIDTH:  mask_w_q  = i_cfg_data[12:0];
                    CFG_MASK_HEIGHT: mask_h_q  = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_rects(i_in);
        end
        o_pending <= expected_rects.size();
    end

endmodule

>>> tb/tb_mask_run_rectangle_extractor_core.sv
// Testbench top for the mask run rectangle extractor: stimulus, register settings and verdict.
module tb_mask_run_rectangle_extractor_core;
    import mrre_pkg::*;

    localparam int MAX_DIM = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_req     i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_res    o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;

    logic signed [15:0] sh_px = '0;
    logic signed [15:0] sh_py = '0;
    logic [12:0]        sh_mw = '0;
    logic [12:0]        sh_mh = '0;

    bit calm = 1'b0;
    int words_left = 0;
    int row_words = 0;
    int counted = 0;
    int n_starts = 0;
    int n_words = 0;
    int n_ignored = 0;
    int n_settings = 1;

    mask_run_rectangle_extractor_core #(
        .MAX_MASK_DIM(MAX_DIM)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    mrre_rect_checker #(
        .MAX_MASK_DIM(MAX_DIM)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("timeout at %0t", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 8);
    end

    function automatic t_in_req random_req();
        t_in_req r;
        r.cmd       = 1'($urandom);
        r.rect_x    = 16'($urandom);
        r.rect_y    = 16'($urandom);
        r.rect_w    = 15'($urandom);
        r.rect_h    = 15'($urandom);
        r.mask_bits = 16'($urandom);
        return r;
    endfunction

    // words the block will take for this start, under the current registers
    function automatic int window_words(input t_in_req r, output int per_row);
        int x0, y0, x1, y1, w, h;
        x0 = int'($signed(r.rect_x)) + int'(sh_px);
        y0 = int'($signed(r.rect_y)) + int'(sh_py);
        x1 = x0 + int'(r.rect_w);
        y1 = y0 + int'(r.rect_h);
        w = (sh_mw > MAX_DIM) ? MAX_DIM : int'(sh_mw);
        h = (sh_mh > MAX_DIM) ? MAX_DIM : int'(sh_mh);
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > w) x1 = w;
        if (y1 > h) y1 = h;
        per_row = 0;
        if (x0 >= x1 || y0 >= y1) return 0;
        per_row = (x1 - 1) / WORD_BITS - x0 / WORD_BITS + 1;
        return per_row * (y1 - y0);
    endfunction

    task automatic send_item(input t_in_req r);
        if (!calm && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_start(input t_in_req r);
        r.cmd = CMD_START;
        words_left = window_words(r, row_words);
        n_starts++;
        counted++;
        send_item(r);
    endtask

    task automatic start_at(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [14:0] w, input logic [14:0] h);
        t_in_req r;
        r = random_req();
        r.rect_x = x;
        r.rect_y = y;
        r.rect_w = w;
        r.rect_h = h;
        send_start(r);
    endtask

    task automatic send_word(input logic [15:0] bits);
        t_in_req r;
        r = random_req();
        r.cmd = CMD_WORD;
        r.mask_bits = bits;
        n_words++;
        if (words_left > 0) begin
            words_left--;
            counted++;
        end else begin
            n_ignored++;
        end
        send_item(r);
    endtask

    task automatic load_config(input logic [15:0] px, input logic [15:0] py,
                               input logic [12:0] mw, input logic [12:0] mh);
        sh_px = px;
        sh_py = py;
        sh_mw = mw;
        sh_mh = mh;
        n_settings++;
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_PHASE_X;
        i_cfg_data <= px;
        @(posedge i_clk);
        i_cfg_addr <= CFG_PHASE_Y;
        i_cfg_data <= py;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MASK_WIDTH;
        i_cfg_data <= {3'b000, mw};
        @(posedge i_clk);
        i_cfg_addr <= CFG_MASK_HEIGHT;
        i_cfg_data <= {3'b000, mh};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // well-formed start plus its words; a broken one stops short
    task automatic random_request(input bit broken);
        int mw, mh, mx, my, n, per_row, style, k;
        logic [15:0] pat [4];
        logic [15:0] bits;
        mw = (sh_mw > MAX_DIM) ? MAX_DIM : int'(sh_mw);
        mh = (sh_mh > MAX_DIM) ? MAX_DIM : int'(sh_mh);
        mx = int'($urandom_range(0, mw + 8)) - 6;
        my = int'($urandom_range(0, mh + 3)) - 2;
        start_at(16'(mx - int'(sh_px)), 16'(my - int'(sh_py)),
                 15'($urandom_range(0, 50)), 15'($urandom_range(0, 4)));
        n = words_left;
        per_row = (row_words > 0) ? row_words : 1;
        if (broken && n > 0) n = $urandom_range(0, n - 1);
        for (k = 0; k < 4; k++) pat[k] = 16'($urandom);
        style = $urandom_range(0, 4);
        for (k = 0; k < n; k++) begin
            case (style)
                0: bits = 16'hFFFF;
                1: bits = 16'h0000;
                2: bits = 16'($urandom);
                3: bits = pat[(k % per_row) % 4];
                default: bits = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                            : pat[(k % per_row) % 4];
            endcase
            send_word(bits);
        end
    endtask

    function automatic logic [15:0] random_phase();
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        return 16'($urandom_range(0, 40000) - 20000);
    endfunction

    function automatic logic [12:0] random_dim();
        if ($urandom_range(0, 9) == 0) return 13'h1FFF;
        return 13'($urandom_range(1, 64));
    endfunction

    initial begin
        t_in_req r;
        int pick;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: zero-sized mask, every window empty
        start_at(16'sd0, 16'sd0, 15'd10, 15'd10);
        send_word(16'hFFFF);
        drain();

        load_config(16'd0, 16'd0, 13'd40, 13'd24);
        start_at(16'sd0, 16'sd0, 15'd16, 15'd1);
        send_word(16'h0000);
        start_at(16'sd0, 16'sd0, 15'd16, 15'd1);
        send_word(16'hAAAA);
        start_at(16'sd0, 16'sd0, 15'd32, 15'd2);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        start_at(16'sd3, 16'sd1, 15'd30, 15'd1);
        send_word(16'hFFFF);
        send_word(16'h5555);
        send_word(16'hFFFF);
        start_at(16'sd0, 16'sd0, 15'd0, 15'd5);
        start_at(16'sd0, 16'sd0, 15'd32, 15'd3);
        send_word(16'hFFFF);
        start_at(-16'sd5, -16'sd5, 15'd7, 15'd6);
        send_word(16'hC000);
        start_at(16'sd39, 16'sd23, 15'd100, 15'd100);
        send_word(16'hFFFF);
        drain();

        // extreme phases, coordinates wrap; mask size saturates
        load_config(16'h8000, 16'h7FFF, 13'h1FFF, 13'h1FFF);
        start_at(16'sh7FFF, -16'sd32767, 15'd20, 15'd2);
        send_word(16'hF00F);
        send_word(16'hFFFF);
        send_word(16'hF00F);
        send_word(16'hFFFF);
        start_at(-16'sd32768, -16'sd32768, 15'h7FFF, 15'h7FFF);
        drain();

        load_config(16'd0, 16'd0, 13'h1FFF, 13'd4096);
        start_at(16'sd4090, 16'sd4095, 15'd100, 15'd100);
        send_word(16'h003F);
        drain();

        counted = 0;
        for (int p = 0; p < 5; p++) begin
            calm = (p == 2);
            load_config(random_phase(), random_phase(), random_dim(), random_dim());
            while (counted < (p + 1) * 16) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    random_request(1'b0);
                end else if (pick < 85) begin
                    random_request(1'b1);
                end else if (pick < 93) begin
                    r = random_req();
                    send_start(r);
                end else begin
                    send_word(16'($urandom));
                end
            end
            drain();
        end

        $display("covered %0d start requests and %0d mask words, %0d of them outside any window",
                 n_starts, n_words, n_ignored);
        $display("over %0d register settings, from a zero-sized mask to saturated size and wrap",
                 n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
